>>> hdl/sbfp_pkg.sv
// Shared types, codes and decode helpers for the spline blob field parser.
// No dependencies; every other file of the block imports this package.
package sbfp_pkg;

    // Parse phase; a record's kind carries the code of the phase that produced it.
    typedef enum logic [4:0] {
        PH_HEADER      = 5'd0,
        PH_PRE_SLOPE   = 5'd1,
        PH_POST_SLOPE  = 5'd2,
        PH_LOOP_START  = 5'd3,
        PH_LOOP_END    = 5'd4,
        PH_PRE_LOOPS   = 5'd5,
        PH_POST_LOOPS  = 5'd6,
        PH_LOOP_OFFSET = 5'd7,
        PH_KNOT_COUNT  = 5'd8,
        PH_FLAG        = 5'd9,
        PH_TIME        = 5'd10,
        PH_VALUE       = 5'd11,
        PH_PRE_VALUE   = 5'd12,
        PH_PRE_WIDTH   = 5'd13,
        PH_POST_WIDTH  = 5'd14,
        PH_PRE_TAN     = 5'd15,
        PH_POST_TAN    = 5'd16,
        PH_ALGO        = 5'd17,
        PH_DONE        = 5'd18
    } phase_t;

    localparam logic [4:0] KIND_END = 5'd18;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_COUNT = 2'd2
    } status_t;

    // value type tags on the record
    localparam logic [1:0] VT_DOUBLE = 2'd0;
    localparam logic [1:0] VT_FLOAT  = 2'd1;
    localparam logic [1:0] VT_HALF   = 2'd2;

    // type descriptor codes in the header (0 and 1 are both double)
    localparam logic [1:0] DESC_FLOAT = 2'd2;
    localparam logic [1:0] DESC_HALF  = 2'd3;

    localparam logic [2:0] EXTRAP_SLOPED = 3'd3;

    localparam int MAX_REC        = 3;
    localparam int REC_CNT_W      = $clog2(MAX_REC + 1);
    localparam int REC_FIFO_DEPTH = 8;

    // Packed header: the fields of the 16-bit header word, with its unused bits dropped.
    typedef struct packed {
        logic       loops;
        logic [2:0] post;
        logic [2:0] pre;
        logic       hermite;
        logic [1:0] desc;
        logic [3:0] version;
    } hdr_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] knot;
        logic [63:0] bits;
        logic [1:0]  vtype;
        logic [3:0]  version;
        logic        hermite;
        logic [2:0]  pre;
        logic [2:0]  post;
        logic        loops;
        status_t     status;
        logic        last;
    } rec_t;

    function automatic hdr_t decode_header(logic [7:0] h1, logic [7:0] h2);
        hdr_t h;
        h.version = h1[3:0];
        h.desc    = h1[5:4];
        h.hermite = h1[7];
        h.pre     = h2[2:0];
        h.post    = h2[5:3];
        h.loops   = h2[6];
        return h;
    endfunction

    function automatic logic [3:0] typed_bytes(logic [1:0] desc);
        logic [3:0] w;
        case (desc)
            DESC_FLOAT: w = 4'd4;
            DESC_HALF:  w = 4'd2;
            default:    w = 4'd8;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] typed_tag(logic [1:0] desc);
        logic [1:0] t;
        case (desc)
            DESC_FLOAT: t = VT_FLOAT;
            DESC_HALF:  t = VT_HALF;
            default:    t = VT_DOUBLE;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] phase_width(phase_t ph, logic [1:0] desc);
        logic [3:0] w;
        case (ph)
            PH_HEADER:                                       w = 4'd2;
            PH_PRE_LOOPS, PH_POST_LOOPS, PH_KNOT_COUNT:      w = 4'd4;
            PH_FLAG, PH_ALGO:                                w = 4'd1;
            PH_VALUE, PH_PRE_VALUE, PH_PRE_TAN, PH_POST_TAN: w = typed_bytes(desc);
            default:                                         w = 4'd8;
        endcase
        return w;
    endfunction

    // Smallest possible knot in bytes: flag, time, value, two slopes,
    // plus widths (non-hermite) and algorithm byte (version 2 and up).
    function automatic logic [5:0] min_knot_bytes(hdr_t h);
        logic [5:0] m;
        case (h.desc)
            DESC_FLOAT: m = 6'd21;
            DESC_HALF:  m = 6'd15;
            default:    m = 6'd33;
        endcase
        if (!h.hermite)
        begin
            m = m + 6'd16;
        end
        if (h.version > 4'd1)
        begin
            m = m + 6'd1;
        end
        return m;
    endfunction

endpackage

>>> hdl/sbfp_core.sv
// Parser state and per-byte field decode for the spline blob field parser.
// Depends on sbfp_pkg. Emits up to MAX_REC records per byte.
module sbfp_core
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     item_valid,
    input  logic [7:0]                               data_byte,
    input  logic                                     blob_start,
    input  logic [31:0]                              blob_bytes,
    output sbfp_pkg::rec_t [sbfp_pkg::MAX_REC-1:0]   recs,
    output logic [sbfp_pkg::REC_CNT_W-1:0]           rec_cnt
);
    import sbfp_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [3:0]  fbc_reg,    fbc_next;
    logic [63:0] shift_reg,  shift_next;
    hdr_t        hdr_reg,    hdr_next;
    logic [31:0] ktot_reg,   ktot_next;
    logic [31:0] kcnt_reg,   kcnt_next;
    logic [31:0] remain_reg, remain_next;   // blob bytes still to come
    logic        dual_reg,   dual_next;

    function automatic phase_t after_preslope(hdr_t h);
        phase_t p;
        if (h.post == EXTRAP_SLOPED)
        begin
            p = PH_POST_SLOPE;
        end
        else if (h.loops)
        begin
            p = PH_LOOP_START;
        end
        else
        begin
            p = PH_KNOT_COUNT;
        end
        return p;
    endfunction

    function automatic phase_t after_preval(hdr_t h);
        return h.hermite ? PH_PRE_TAN : PH_PRE_WIDTH;
    endfunction

    function automatic rec_t make_rec(logic [4:0] kind, logic [31:0] knot,
                                      logic [63:0] bits, logic [1:0] vtype,
                                      status_t st);
        rec_t r;
        r         = '0;
        r.kind    = kind;
        r.knot    = knot;
        r.bits    = bits;
        r.vtype   = vtype;
        r.status  = st;
        r.last    = (kind == KIND_END);
        return r;
    endfunction

    always_comb
    begin
        phase_t                 cur_ph;
        logic [3:0]             cur_fbc;
        logic [63:0]            cur_sh;
        logic [63:0]            sh1;
        logic [3:0]             fbc1;
        logic [63:0]            v;
        logic [31:0]            ki;
        logic [1:0]             ty;
        logic [37:0]            need;
        logic [REC_CNT_W-1:0]   n;
        logic                   go;

        phase_next  = phase_reg;
        fbc_next    = fbc_reg;
        shift_next  = shift_reg;
        hdr_next    = hdr_reg;
        ktot_next   = ktot_reg;
        kcnt_next   = kcnt_reg;
        remain_next = remain_reg;
        dual_next   = dual_reg;
        recs        = '0;
        n           = '0;
        cur_ph      = phase_reg;
        cur_fbc     = fbc_reg;
        cur_sh      = shift_reg;
        sh1         = '0;
        fbc1        = '0;
        v           = '0;
        ki          = '0;
        ty          = VT_DOUBLE;
        need        = '0;
        go          = 1'b0;

        if (item_valid)
        begin
            if (blob_start)
            begin
                // restart: clear all parse state, take the new length
                cur_ph      = PH_HEADER;
                cur_fbc     = '0;
                cur_sh      = '0;
                phase_next  = PH_HEADER;
                hdr_next    = '0;
                ktot_next   = '0;
                kcnt_next   = '0;
                dual_next   = 1'b0;
                remain_next = blob_bytes;
                fbc_next    = '0;
                shift_next  = '0;
                if (blob_bytes == 32'd0)
                begin
                    // empty blob: truncated end, byte not consumed
                    recs[n]    = make_rec(KIND_END, 32'd0, 64'd0, VT_DOUBLE, ST_TRUNC);
                    n          = n + 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    go = 1'b1;
                end
            end
            else if (phase_reg != PH_DONE && remain_reg != 32'd0)
            begin
                go = 1'b1;
            end
        end

        if (go)
        begin
            remain_next = remain_next - 32'd1;
            sh1  = cur_sh | ({56'd0, data_byte} << {cur_fbc[2:0], 3'b000});
            fbc1 = cur_fbc + 4'd1;
            if (fbc1 >= phase_width(cur_ph, hdr_next.desc))
            begin
                v          = sh1;
                shift_next = '0;
                fbc_next   = '0;
                if (cur_ph == PH_HEADER)
                begin
                    hdr_next = decode_header(v[7:0], v[15:8]);
                end
                ki = (cur_ph >= PH_FLAG) ? kcnt_next : 32'd0;
                ty = (cur_ph inside {PH_VALUE, PH_PRE_VALUE, PH_PRE_TAN, PH_POST_TAN})
                     ? typed_tag(hdr_next.desc) : VT_DOUBLE;
                recs[n] = make_rec(5'(cur_ph), ki, v, ty, ST_OK);
                n       = n + 1'b1;

                case (cur_ph)
                    PH_HEADER:
                    begin
                        phase_next = (hdr_next.pre == EXTRAP_SLOPED)
                                     ? PH_PRE_SLOPE : after_preslope(hdr_next);
                    end
                    PH_PRE_SLOPE:   phase_next = after_preslope(hdr_next);
                    PH_POST_SLOPE:  phase_next = hdr_next.loops ? PH_LOOP_START
                                                                : PH_KNOT_COUNT;
                    PH_LOOP_START:  phase_next = PH_LOOP_END;
                    PH_LOOP_END:    phase_next = PH_PRE_LOOPS;
                    PH_PRE_LOOPS:   phase_next = PH_POST_LOOPS;
                    PH_POST_LOOPS:  phase_next = PH_LOOP_OFFSET;
                    PH_LOOP_OFFSET: phase_next = PH_KNOT_COUNT;
                    PH_KNOT_COUNT:
                    begin
                        // count > remain / minb  <=>  count * minb > remain
                        ktot_next = v[31:0];
                        kcnt_next = '0;
                        need = {6'd0, v[31:0]} * {32'd0, min_knot_bytes(hdr_next)};
                        if (need > {6'd0, remain_next})
                        begin
                            recs[n]    = make_rec(KIND_END, 32'd0, 64'd0, VT_DOUBLE,
                                                  ST_COUNT);
                            n          = n + 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (v[31:0] == 32'd0)
                        begin
                            recs[n]    = make_rec(KIND_END, 32'd0, 64'd0, VT_DOUBLE,
                                                  ST_OK);
                            n          = n + 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_FLAG;
                        end
                    end
                    PH_FLAG:
                    begin
                        dual_next  = v[0];
                        phase_next = PH_TIME;
                    end
                    PH_TIME:        phase_next = PH_VALUE;
                    PH_VALUE:
                    begin
                        if (dual_next)
                        begin
                            phase_next = PH_PRE_VALUE;
                        end
                        else
                        begin
                            // single-valued knot: pre-value mirrors the value
                            recs[n]    = make_rec(5'(PH_PRE_VALUE), ki, v, ty, ST_OK);
                            n          = n + 1'b1;
                            phase_next = after_preval(hdr_next);
                        end
                    end
                    PH_PRE_VALUE:   phase_next = after_preval(hdr_next);
                    PH_PRE_WIDTH:   phase_next = PH_POST_WIDTH;
                    PH_POST_WIDTH:  phase_next = PH_PRE_TAN;
                    PH_PRE_TAN:     phase_next = PH_POST_TAN;
                    default:
                    begin
                        // post tangent (knot end up to version 1) or algorithm byte
                        if (cur_ph == PH_POST_TAN && hdr_next.version > 4'd1)
                        begin
                            phase_next = PH_ALGO;
                        end
                        else
                        begin
                            kcnt_next = kcnt_next + 32'd1;
                            if (kcnt_next == ktot_next)
                            begin
                                recs[n]    = make_rec(KIND_END, kcnt_next, 64'd0,
                                                      VT_DOUBLE, ST_OK);
                                n          = n + 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_FLAG;
                            end
                        end
                    end
                endcase
            end
            else
            begin
                shift_next = sh1;
                fbc_next   = fbc1;
            end

            if (phase_next != PH_DONE && remain_next == 32'd0)
            begin
                recs[n]    = make_rec(KIND_END, kcnt_next, 64'd0, VT_DOUBLE, ST_TRUNC);
                n          = n + 1'b1;
                phase_next = PH_DONE;
            end
        end

        // every record of a byte carries the header as it stands after that byte
        for (int i = 0; i < MAX_REC; i++)
        begin
            recs[i].version = hdr_next.version;
            recs[i].hermite = hdr_next.hermite;
            recs[i].pre     = hdr_next.pre;
            recs[i].post    = hdr_next.post;
            recs[i].loops   = hdr_next.loops;
        end
        rec_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            fbc_reg    <= '0;
            shift_reg  <= '0;
            hdr_reg    <= '0;
            ktot_reg   <= '0;
            kcnt_reg   <= '0;
            remain_reg <= '0;
            dual_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            shift_reg  <= shift_next;
            hdr_reg    <= hdr_next;
            ktot_reg   <= ktot_next;
            kcnt_reg   <= kcnt_next;
            remain_reg <= remain_next;
            dual_reg   <= dual_next;
        end
    end

endmodule

>>> hdl/sbfp_fifo.sv
// Record queue: takes up to MAX_REC records per cycle, hands out one.
// Depends on sbfp_pkg.
module sbfp_fifo
#(
    parameter int DEPTH = sbfp_pkg::REC_FIFO_DEPTH
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  sbfp_pkg::rec_t [sbfp_pkg::MAX_REC-1:0]   push_recs,
    input  logic [sbfp_pkg::REC_CNT_W-1:0]           push_cnt,
    input  logic                                     pop,
    output sbfp_pkg::rec_t                           head,
    output logic                                     not_empty,
    output logic [$clog2(DEPTH+1)-1:0]               fill
);
    import sbfp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t            mem [DEPTH];
    logic [AW-1:0]   wp_reg, wp_next;
    logic [AW-1:0]   rp_reg, rp_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [AW-1:0]   waddr [MAX_REC];

    function automatic logic [AW-1:0] wrap(logic [AW:0] s);
        logic [AW:0] r;
        r = s;
        if (r >= (AW+1)'(DEPTH))
        begin
            r = r - (AW+1)'(DEPTH);
        end
        return r[AW-1:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < MAX_REC; i++)
        begin
            waddr[i] = wrap({1'b0, wp_reg} + (AW+1)'(i));
        end
        wp_next   = wrap({1'b0, wp_reg} + (AW+1)'(push_cnt));
        rp_next   = pop ? wrap({1'b0, rp_reg} + (AW+1)'(1)) : rp_reg;
        fill_next = fill_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_REC; i++)
        begin
            if (REC_CNT_W'(i) < push_cnt)
            begin
                mem[waddr[i]] <= push_recs[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    assign head      = mem[rp_reg];
    assign not_empty = (fill_reg != '0);
    assign fill      = fill_reg;

endmodule

>>> hdl/spline_blob_field_parser_top.sv
// Spline blob field parser, top level: input stage, parser core, record queue.
// Depends on sbfp_pkg, sbfp_core and sbfp_fifo.
//
// Use:
//   Input channel (in_valid/in_ready) carries one blob byte per word, with
//   blob_start marking the first byte of a blob and blob_bytes its length
//   (sampled with that first byte). Output channel (out_valid/out_ready)
//   carries one decoded record per word: header, slopes, loop fields, knot
//   count, knot fields and a closing end record with status and last set.
//   Throughput: one byte per cycle while in_ready is high. A byte produces
//   zero to three records; the queue absorbs bursts and in_ready only drops
//   when it could not take the records of the staged byte plus a new one.
//   Path: a byte that completes a record is registered in the input stage,
//   decoded by the parser core and written into the queue, which offers it.
//   Stall: with out_ready low records wait in the queue (REC_DEPTH words),
//   and in_ready falls once fewer than three free slots stay guaranteed.
//   Reset: parser idles waiting for a blob start, queue and stage empty;
//   bytes that arrive with no blob open are taken and dropped.
//   Trailing bytes after a blob's end record are also taken and dropped.
module spline_blob_field_parser_top
#(
    parameter int REC_DEPTH = sbfp_pkg::REC_FIFO_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         blob_start,
    input  logic [31:0]  blob_bytes,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [4:0]   record_kind,
    output logic [31:0]  knot_index,
    output logic [63:0]  value_bits,
    output logic [1:0]   value_type,
    output logic [3:0]   format_version,
    output logic         hermite_curve,
    output logic [2:0]   pre_extrap_mode,
    output logic [2:0]   post_extrap_mode,
    output logic         loops_present,
    output logic [1:0]   status,
    output logic         last
);
    import sbfp_pkg::*;

    localparam int CW = $clog2(REC_DEPTH + 1);

    // input stage
    logic         stage_valid_reg;
    logic [7:0]   stage_byte_reg;
    logic         stage_start_reg;
    logic [31:0]  stage_len_reg;

    rec_t [MAX_REC-1:0]    core_recs;
    logic [REC_CNT_W-1:0]  core_cnt;
    rec_t                  head;
    logic                  q_not_empty;
    logic [CW-1:0]         q_fill;
    logic [CW:0]           committed;

    // slots spoken for: queued words plus worst case of the staged byte
    assign committed = {1'b0, q_fill} + (stage_valid_reg ? (CW+1)'(MAX_REC) : '0);
    assign in_ready  = (committed <= (CW+1)'(REC_DEPTH - MAX_REC));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= in_valid && in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_byte_reg  <= data_byte;
            stage_start_reg <= blob_start;
            stage_len_reg   <= blob_bytes;
        end
    end

    sbfp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stage_valid_reg),
        .data_byte  (stage_byte_reg),
        .blob_start (stage_start_reg),
        .blob_bytes (stage_len_reg),
        .recs       (core_recs),
        .rec_cnt    (core_cnt)
    );

    sbfp_fifo #(.DEPTH(REC_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_recs (core_recs),
        .push_cnt  (core_cnt),
        .pop       (out_valid && out_ready),
        .head      (head),
        .not_empty (q_not_empty),
        .fill      (q_fill)
    );

    assign out_valid        = q_not_empty;
    assign record_kind      = head.kind;
    assign knot_index       = head.knot;
    assign value_bits       = head.bits;
    assign value_type       = head.vtype;
    assign format_version   = head.version;
    assign hermite_curve    = head.hermite;
    assign pre_extrap_mode  = head.pre;
    assign post_extrap_mode = head.post;
    assign loops_present    = head.loops;
    assign status           = head.status;
    assign last             = head.last;

    // error status only ever closes a blob
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("nonzero status on a non-final record");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> record_kind == KIND_END)
        else $error("last flag on a record that is not an end record");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_fill <= CW'(REC_DEPTH))
        else $error("record queue overflow");

    a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> stage_valid_reg)
        else $error("accepted byte did not reach the input stage");

endmodule

>>> tb/spline_blob_field_parser_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for spline_blob_field_parser_top: random and directed blobs in,
// decoded records checked against an in-bench model of the parser.
// Depends on sbfp_pkg and the parser RTL.
module spline_blob_field_parser_top_tb;
    import sbfp_pkg::*;

    // Idling phases, chosen from how far the input stream has progressed.
    localparam int MODE_FREE      = 0;   // no gaps on either side
    localparam int MODE_PRESSURE  = 1;   // one long receiver hold, sender pushes on
    localparam int MODE_TX_GAPS   = 2;   // sender idle half the time
    localparam int MODE_RX_STALLS = 3;   // receiver stalls half the time
    localparam int MODE_BOTH      = 4;   // both, a third of the time

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 320;

    // One input word: a blob byte with its start mark and length.
    typedef struct {
        logic [7:0]  data;
        logic        start;
        logic [31:0] len;
    } stim_word_t;

    // One decoded record, as the output port set carries it.
    typedef struct {
        logic [4:0]  kind;
        logic [31:0] knot;
        logic [63:0] bits;
        logic [1:0]  vtype;
        logic [3:0]  version;
        logic        hermite;
        logic [2:0]  pre;
        logic [2:0]  post;
        logic        loops;
        logic [1:0]  status;
        logic        last;
    } parse_rec_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte  = '0;
    logic        blob_start = 1'b0;
    logic [31:0] blob_bytes = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [4:0]  record_kind;
    logic [31:0] knot_index;
    logic [63:0] value_bits;
    logic [1:0]  value_type;
    logic [3:0]  format_version;
    logic        hermite_curve;
    logic [2:0]  pre_extrap_mode;
    logic [2:0]  post_extrap_mode;
    logic        loops_present;
    logic [1:0]  status;
    logic        last;

    spline_blob_field_parser_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .blob_start       (blob_start),
        .blob_bytes       (blob_bytes),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .record_kind      (record_kind),
        .knot_index       (knot_index),
        .value_bits       (value_bits),
        .value_type       (value_type),
        .format_version   (format_version),
        .hermite_curve    (hermite_curve),
        .pre_extrap_mode  (pre_extrap_mode),
        .post_extrap_mode (post_extrap_mode),
        .loops_present    (loops_present),
        .status           (status),
        .last             (last)
    );

    stim_word_t  byte_queue[$];        // words still to offer
    parse_rec_t  pending_records[$];   // decoded records not yet seen at the output
    logic [7:0]  blob_buf[$];          // blob under construction

    int total_words;
    int words_in;
    int records_seen;
    int mismatches;
    int ends_ok, ends_trunc, ends_count;
    int idle_mode = MODE_FREE;
    int hold_cnt  = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Parser model state: mirrors what the block must track per blob.
    // ------------------------------------------------------------------
    phase_t      ps_phase = PH_HEADER;
    int unsigned ps_nbytes = 0;        // bytes gathered for the current field
    logic [63:0] ps_acc = '0;          // little-endian field accumulator
    logic [31:0] ps_knots = '0;        // knot count from the blob
    logic [31:0] ps_knot = '0;         // knots completed so far
    logic [31:0] ps_pos = '0;          // bytes consumed
    logic [31:0] ps_len = '0;          // declared blob length
    logic        ps_dual = 1'b0;
    // decoded header
    logic [3:0]  hd_ver = '0;
    logic [1:0]  hd_desc = '0;
    logic        hd_herm = 1'b0;
    logic [2:0]  hd_pre = '0;
    logic [2:0]  hd_post = '0;
    logic        hd_loops = 1'b0;

    function automatic void clear_parser();
        ps_phase  = PH_HEADER;
        ps_nbytes = 0;
        ps_acc    = '0;
        ps_knots  = '0;
        ps_knot   = '0;
        ps_pos    = '0;
        ps_len    = '0;
        ps_dual   = 1'b0;
        hd_ver    = '0;
        hd_desc   = '0;
        hd_herm   = 1'b0;
        hd_pre    = '0;
        hd_post   = '0;
        hd_loops  = 1'b0;
    endfunction

    // Width of a typed element (value, pre-value, tangent slope).
    function automatic int unsigned elem_size();
        if (hd_desc == DESC_FLOAT)
            return 4;
        else if (hd_desc == DESC_HALF)
            return 2;
        return 8;
    endfunction

    function automatic logic [1:0] elem_tag();
        if (hd_desc == DESC_FLOAT)
            return VT_FLOAT;
        else if (hd_desc == DESC_HALF)
            return VT_HALF;
        return VT_DOUBLE;
    endfunction

    function automatic int unsigned field_len(phase_t p);
        case (p)
            PH_HEADER:                                       return 2;
            PH_PRE_LOOPS, PH_POST_LOOPS, PH_KNOT_COUNT:      return 4;
            PH_FLAG, PH_ALGO:                                return 1;
            PH_VALUE, PH_PRE_VALUE, PH_PRE_TAN, PH_POST_TAN: return elem_size();
            default:                                         return 8;
        endcase
    endfunction

    function automatic void emit_record(logic [4:0] kind, logic [31:0] knot,
                                        logic [63:0] bits, logic [1:0] vtype,
                                        logic [1:0] st);
        parse_rec_t r;
        r.kind    = kind;
        r.knot    = knot;
        r.bits    = bits;
        r.vtype   = vtype;
        r.version = hd_ver;
        r.hermite = hd_herm;
        r.pre     = hd_pre;
        r.post    = hd_post;
        r.loops   = hd_loops;
        r.status  = st;
        r.last    = (kind == KIND_END);
        pending_records.insert(pending_records.size(), r);
    endfunction

    function automatic void close_blob(logic [1:0] st);
        emit_record(KIND_END, ps_knot, '0, VT_DOUBLE, st);
        ps_phase = PH_DONE;
    endfunction

    function automatic phase_t after_pre_slope();
        if (hd_post == EXTRAP_SLOPED)
            return PH_POST_SLOPE;
        return hd_loops ? PH_LOOP_START : PH_KNOT_COUNT;
    endfunction

    function automatic void finish_knot();
        ps_knot = ps_knot + 1;
        if (ps_knot == ps_knots)
            close_blob(ST_OK);
        else
            ps_phase = PH_FLAG;
    endfunction

    // A field has all its bytes: emit its record and step to the next field.
    function automatic void field_complete(logic [63:0] v);
        logic [31:0] kidx;
        logic [1:0]  vt;
        logic [31:0] min_knot;
        logic [31:0] remain;
        kidx = (ps_phase >= PH_FLAG) ? ps_knot : 32'd0;
        vt   = (ps_phase == PH_VALUE || ps_phase == PH_PRE_VALUE ||
                ps_phase == PH_PRE_TAN || ps_phase == PH_POST_TAN) ? elem_tag() : VT_DOUBLE;
        if (ps_phase == PH_HEADER)
        begin
            hd_ver   = v[3:0];
            hd_desc  = v[5:4];
            hd_herm  = v[7];
            hd_pre   = v[10:8];
            hd_post  = v[13:11];
            hd_loops = v[14];
        end
        emit_record(ps_phase, kidx, v, vt, ST_OK);
        case (ps_phase)
            PH_HEADER:      ps_phase = (hd_pre == EXTRAP_SLOPED) ? PH_PRE_SLOPE
                                                                  : after_pre_slope();
            PH_PRE_SLOPE:   ps_phase = after_pre_slope();
            PH_POST_SLOPE:  ps_phase = hd_loops ? PH_LOOP_START : PH_KNOT_COUNT;
            PH_LOOP_START:  ps_phase = PH_LOOP_END;
            PH_LOOP_END:    ps_phase = PH_PRE_LOOPS;
            PH_PRE_LOOPS:   ps_phase = PH_POST_LOOPS;
            PH_POST_LOOPS:  ps_phase = PH_LOOP_OFFSET;
            PH_LOOP_OFFSET: ps_phase = PH_KNOT_COUNT;
            PH_KNOT_COUNT:
            begin
                // smallest knot: flag, time, value, two slopes (+widths, +algo byte)
                min_knot = 32'd9 + 32'd3 * elem_size();
                if (!hd_herm)
                    min_knot = min_knot + 32'd16;
                if (hd_ver > 4'd1)
                    min_knot = min_knot + 32'd1;
                remain   = ps_len - ps_pos;
                ps_knots = v[31:0];
                ps_knot  = '0;
                if (ps_knots > remain / min_knot)
                    close_blob(ST_COUNT);
                else if (ps_knots == 0)
                    close_blob(ST_OK);
                else
                    ps_phase = PH_FLAG;
            end
            PH_FLAG:
            begin
                ps_dual  = v[0];
                ps_phase = PH_TIME;
            end
            PH_TIME:        ps_phase = PH_VALUE;
            PH_VALUE:
                if (ps_dual)
                    ps_phase = PH_PRE_VALUE;
                else
                begin
                    // single-valued knot: pre-value mirrors the value
                    emit_record(PH_PRE_VALUE, kidx, v, vt, ST_OK);
                    ps_phase = hd_herm ? PH_PRE_TAN : PH_PRE_WIDTH;
                end
            PH_PRE_VALUE:   ps_phase = hd_herm ? PH_PRE_TAN : PH_PRE_WIDTH;
            PH_PRE_WIDTH:   ps_phase = PH_POST_WIDTH;
            PH_POST_WIDTH:  ps_phase = PH_PRE_TAN;
            PH_PRE_TAN:     ps_phase = PH_POST_TAN;
            PH_POST_TAN:
                if (hd_ver > 4'd1)
                    ps_phase = PH_ALGO;
                else
                    finish_knot();
            default:        finish_knot();
        endcase
    endfunction

    // Apply one accepted input word to the model.
    function automatic void decode_byte(logic [7:0] b, logic start, logic [31:0] len);
        logic [63:0] v;
        if (start)
        begin
            clear_parser();
            ps_len = len;
            if (len == 0)
            begin
                close_blob(ST_TRUNC);
                return;
            end
        end
        else if (ps_phase == PH_DONE || ps_pos >= ps_len)
            return;
        ps_pos    = ps_pos + 1;
        ps_acc    = ps_acc | ({56'd0, b} << (ps_nbytes * 8));
        ps_nbytes = ps_nbytes + 1;
        if (ps_nbytes >= field_len(ps_phase))
        begin
            v         = ps_acc;
            ps_acc    = '0;
            ps_nbytes = 0;
            field_complete(v);
        end
        if (ps_phase != PH_DONE && ps_pos >= ps_len)
            close_blob(ST_TRUNC);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void push_word(logic [7:0] d, logic s, logic [31:0] len);
        stim_word_t w;
        w.data  = d;
        w.start = s;
        w.len   = len;
        byte_queue.insert(byte_queue.size(), w);
    endfunction

    // little-endian field into the blob under construction
    function automatic void add_field(logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
            blob_buf.insert(blob_buf.size(), v[8*i +: 8]);
    endfunction

    function automatic void send_blob(logic [31:0] len, int n);
        for (int i = 0; i < n; i++)
            push_word(blob_buf[i], i == 0, len);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // One random blob, mostly well formed; some cut short, some with a bad knot
    // count, some left open with a huge length and abandoned by the next start.
    // Returns the number of words queued.
    function automatic int add_random_blob();
        logic [3:0]  ver;
        logic [1:0]  desc;
        logic        herm, loops, tv, spare;
        logic [2:0]  pre, post;
        logic [7:0]  flag;
        logic [31:0] cnt, len;
        int          tsz, nk, style, count_end, nsend;
        ver   = $urandom_range(0, 15);
        desc  = $urandom_range(0, 1) ? DESC_HALF : 2'($urandom_range(0, 3));
        herm  = $urandom_range(0, 1);
        loops = $urandom_range(0, 2) == 0;
        tv    = $urandom_range(0, 1);
        spare = $urandom_range(0, 1);
        pre   = $urandom_range(0, 1) ? EXTRAP_SLOPED : 3'($urandom_range(0, 7));
        post  = $urandom_range(0, 1) ? EXTRAP_SLOPED : 3'($urandom_range(0, 7));
        tsz   = (desc == DESC_FLOAT) ? 4 : (desc == DESC_HALF) ? 2 : 8;
        nk    = $urandom_range(0, 3);
        style = $urandom_range(0, 9);
        cnt   = (style == 8) ? ($urandom() | 32'h100) : nk;

        blob_buf.delete();
        add_field({herm, tv, desc, ver}, 1);
        add_field({spare, loops, post, pre}, 1);
        if (pre == EXTRAP_SLOPED)
            add_field(rand64(), 8);
        if (post == EXTRAP_SLOPED)
            add_field(rand64(), 8);
        if (loops)
        begin
            add_field(rand64(), 8);
            add_field(rand64(), 8);
            add_field($urandom(), 4);
            add_field($urandom(), 4);
            add_field(rand64(), 8);
        end
        add_field(cnt, 4);
        count_end = blob_buf.size();
        for (int k = 0; k < nk; k++)
        begin
            flag = $urandom_range(0, 255);
            add_field(flag, 1);
            add_field(rand64(), 8);
            add_field(rand64(), tsz);
            if (flag[0])
                add_field(rand64(), tsz);
            if (!herm)
            begin
                add_field(rand64(), 8);
                add_field(rand64(), 8);
            end
            add_field(rand64(), tsz);
            add_field(rand64(), tsz);
            if (ver > 4'd1)
                add_field($urandom_range(0, 255), 1);
        end

        if (style <= 5)
        begin
            // well formed; sometimes padding inside the declared length
            if ($urandom_range(0, 3) == 0)
                add_field(rand64(), $urandom_range(1, 4));
            len   = blob_buf.size();
            nsend = blob_buf.size();
        end
        else if (style <= 7)
        begin
            len   = $urandom_range(1, blob_buf.size() - 1);
            nsend = len;
        end
        else if (style == 8)
        begin
            // count overflows: everything past the count is dropped, send little of it
            len   = blob_buf.size();
            nsend = (count_end + 2 < blob_buf.size()) ? count_end + 2 : blob_buf.size();
        end
        else
        begin
            len   = $urandom() | 32'h8000_0000;
            nsend = $urandom_range(1, blob_buf.size());
        end
        send_blob(len, nsend);
        return nsend;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int rand_words;
        // Directed opening.
        push_word(8'hFF, 1'b0, 32'hFFFF_FFFF);   // no blob open: dropped
        push_word(8'hA5, 1'b1, 32'd0);           // empty blob: lone truncated end
        push_word(8'h5A, 1'b0, 32'd0);           // after the end: dropped
        // zero knots, minimal header, then one byte past the length
        blob_buf.delete();
        add_field(64'h0, 2);
        add_field(64'h0, 4);
        send_blob(32'd6, 6);
        push_word(8'hFF, 1'b0, 32'd0);
        // hermite half, 15 bytes left after the count: two knots cannot fit
        blob_buf.delete();
        add_field({1'b1, 1'b0, DESC_HALF, 4'h0}, 1);
        add_field(8'h00, 1);
        add_field(64'd2, 4);
        send_blob(32'd21, 6);
        // all header bits set, blob ends right after the header
        blob_buf.delete();
        add_field(16'hFFFF, 2);
        send_blob(32'd2, 2);
        // blob ends inside the header
        push_word(8'h00, 1'b1, 32'd1);
        // largest length, abandoned by the next start
        push_word(8'h3C, 1'b1, 32'hFFFF_FFFF);

        rand_words = 0;
        while (rand_words < RANDOM_BYTES)
            rand_words += add_random_blob();
        total_words = byte_queue.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // all words offered and taken, then every record back, then a short drain
        while (byte_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input words (%0d random), %0d records checked.",
                 words_in, rand_words, records_seen);
        $display("Blob ends seen: %0d clean, %0d truncated, %0d knot count overflow.",
                 ends_ok, ends_trunc, ends_count);
        if (mismatches == 0 && pending_records.size() == 0)
            $display("** spline_blob_field_parser_top: PASSED **");
        else
            $display("** spline_blob_field_parser_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: offers queued words, predicts records on each accepted word.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sender
        stim_word_t w;
        int         gap_pct;
        int         m;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= '0;
            blob_start <= 1'b0;
            blob_bytes <= '0;
            idle_mode  <= MODE_FREE;
            words_in    = 0;
            clear_parser();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte, blob_start, blob_bytes);
                words_in++;
            end
            m = (words_in * 5) / total_words;
            idle_mode <= (m > MODE_BOTH) ? MODE_BOTH : m;
            gap_pct = (idle_mode == MODE_TX_GAPS) ? 50 : (idle_mode == MODE_BOTH) ? 34 : 0;
            // a new word may go out only when nothing is waiting or it was just taken
            if (!in_valid || in_ready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    w = byte_queue.pop_front();
                    in_valid   <= 1'b1;
                    data_byte  <= w.data;
                    blob_start <= w.start;
                    blob_bytes <= w.len;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, at the start of the pressure phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (idle_mode == MODE_PRESSURE && !hold_done)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // ------------------------------------------------------------------
    // Receiver: checks each record against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic bit field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : receiver
        parse_rec_t want;
        bit         bad;
        int         stall_pct;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            records_seen  = 0;
            mismatches    = 0;
            ends_ok       = 0;
            ends_trunc    = 0;
            ends_count    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                records_seen++;
                if (pending_records.size() == 0)
                begin
                    $display("%0t: record with nothing expected, expected none, got kind %0d",
                             $time, record_kind);
                    mismatches++;
                end
                else
                begin
                    want = pending_records.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("record_kind", want.kind, record_kind);
                    bad |= field_differs("knot_index", want.knot, knot_index);
                    bad |= field_differs("value_bits", want.bits, value_bits);
                    bad |= field_differs("value_type", want.vtype, value_type);
                    bad |= field_differs("format_version", want.version, format_version);
                    bad |= field_differs("hermite_curve", want.hermite, hermite_curve);
                    bad |= field_differs("pre_extrap_mode", want.pre, pre_extrap_mode);
                    bad |= field_differs("post_extrap_mode", want.post, post_extrap_mode);
                    bad |= field_differs("loops_present", want.loops, loops_present);
                    bad |= field_differs("status", want.status, status);
                    bad |= field_differs("last", want.last, last);
                    if (bad)
                        mismatches++;
                    if (want.last)
                    begin
                        if (want.status == ST_OK)
                            ends_ok++;
                        else if (want.status == ST_TRUNC)
                            ends_trunc++;
                        else
                            ends_count++;
                    end
                end
            end
            stall_pct = (idle_mode == MODE_RX_STALLS) ? 50 :
                        (idle_mode == MODE_BOTH) ? 34 : 0;
            out_ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d records outstanding",
                         $time, quiet_cycles, pending_records.size());
                $display("** spline_blob_field_parser_top: FAILED **");
                $finish;
            end
        end
    end

endmodule
